>>> sv/assert_macros.svh
// Assertion macros used by the RTL of the arithmetic encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define AAE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define AAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/aae_pkg.sv
// Package with constants and handshake types of the arithmetic encoder.
`timescale 1ns / 1ps
package aae_pkg;

    localparam int CODE_BITS    = 32;
    localparam int TOP_BIT      = CODE_BITS - 1;
    localparam int FREQ_W       = 16;
    localparam int SYM_W        = 9;
    localparam int IDX_W        = 10;
    localparam int MAX_ALPHABET = 511;
    localparam int NUM_IDX      = MAX_ALPHABET + 2;
    localparam int NUM_SYM      = MAX_ALPHABET + 1;
    localparam int TOTAL_LIMIT  = 65535;
    localparam int PROD_W       = FREQ_W + CODE_BITS;
    localparam int MD_CNT_W     = $clog2(PROD_W + 1);
    localparam int NBIT_W       = $clog2(CODE_BITS + 1);

    localparam logic [SYM_W-1:0] ALPHA_RESET = SYM_W'(256);

    // Request to the shared multiply-divide unit
    typedef struct packed {
        logic                 start;
        logic [FREQ_W-1:0]    mult;
        logic [CODE_BITS-1:0] span;
        logic [FREQ_W-1:0]    divisor;
    } md_req_t;

    // Answer of the shared multiply-divide unit
    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [CODE_BITS-1:0] quotient;
    } md_rsp_t;

endpackage

>>> sv/aae_if.sv
// Handshake channels of the arithmetic encoder: symbols in, bits out, configuration.
`timescale 1ns / 1ps
interface aae_sym_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [aae_pkg::SYM_W-1:0] symbol;
    modport source (output valid, output action, output symbol, input ready);
    modport sink (input valid, input action, input symbol, output ready);
endinterface

interface aae_bit_if;
    logic                          valid;
    logic                          ready;
    logic                          lead_bit;
    logic [aae_pkg::CODE_BITS-1:0] follow_count;
    logic                          last;
    modport source (output valid, output lead_bit, output follow_count, output last,
                    input ready);
    modport sink (input valid, input lead_bit, input follow_count, input last,
                  output ready);
endinterface

interface aae_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [aae_pkg::SYM_W-1:0] max_symbol;
    modport source (output valid, output max_symbol, input ready);
    modport sink (input valid, input max_symbol, output ready);
endinterface

>>> sv/aae_ram.sv
// Single write port, single registered read port memory for the model tables.
`timescale 1ns / 1ps
module aae_ram #(
    parameter int DEPTH = 513,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/aae_muldiv.sv
// Shared unit: one multiply, then a restoring divide one quotient bit a cycle.
`timescale 1ns / 1ps
module aae_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  aae_pkg::md_req_t req,
    output aae_pkg::md_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [aae_pkg::MD_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [aae_pkg::PROD_W-1:0]          dvd_reg, dvd_next;
    logic [aae_pkg::FREQ_W-1:0]          rem_reg, rem_next;
    logic [aae_pkg::FREQ_W-1:0]          div_reg, div_next;
    logic [aae_pkg::FREQ_W:0]            trial;

    // Load the product on start, then shift one bit of it into the remainder a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, dvd_reg[aae_pkg::PROD_W-1]};
        if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = aae_pkg::FREQ_W'(trial - {1'b0, div_reg});
                dvd_next = {dvd_reg[aae_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[aae_pkg::FREQ_W-1:0];
                dvd_next = {dvd_reg[aae_pkg::PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - aae_pkg::MD_CNT_W'(1);
            if (cnt_reg == aae_pkg::MD_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = aae_pkg::MD_CNT_W'(aae_pkg::PROD_W);
            dvd_next  = aae_pkg::PROD_W'(req.mult) * aae_pkg::PROD_W'(req.span);
            rem_next  = '0;
            div_next  = req.divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg[aae_pkg::CODE_BITS-1:0];

endmodule

>>> sv/adaptive_arithmetic_encoder.sv
// Adaptive arithmetic encoder: one symbol per transfer, settled bits with their
// pending complement counts out. The block takes one symbol at a time and drops
// ready until that symbol is fully coded. An item runs the two range products
// through the shared multiply-divide unit, emits each settled bit, does each
// underflow shift, halves the table when the total reaches its limit, steps the
// equal-frequency search and updates each cumulative entry above the symbol; all
// table walks run on memories with one write port and one registered read port.
// After reset and after every max_symbol write the tables are rebuilt in a
// clearing pass over every entry during which no symbol is taken. Output stalls
// hold the coder at the next bit.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adaptive_arithmetic_encoder (
    input  logic     clk,
    input  logic     rst_n,
    aae_cfg_if.sink  cfg,
    aae_sym_if.sink  sym_in,
    aae_bit_if.source bit_out
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_IDX, S_IDX_W, S_TOT, S_CHI, S_CLO, S_DIV_HI, S_DIV_LO,
        S_SETTLE, S_UFLOW, S_FINAL, S_ADAPT, S_H_RD, S_H_WR, S_F_RD, S_F_REF,
        S_S_RD, S_S_CMP, S_SW_A, S_SW_B, S_SW_C, S_SW_D, S_SW_E, S_INC, S_C_RD, S_C_WR
    } state_t;

    localparam int CB = aae_pkg::CODE_BITS;
    localparam int FW = aae_pkg::FREQ_W;
    localparam int IW = aae_pkg::IDX_W;
    localparam int SW = aae_pkg::SYM_W;
    localparam int NW = aae_pkg::NBIT_W;

    state_t              state_reg, state_next;
    logic [SW-1:0]       alpha_reg, alpha_next;
    logic                action_reg, action_next;
    logic [SW-1:0]       sym_reg, sym_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [FW-1:0]       tot_raw_reg, tot_raw_next;
    logic [FW-1:0]       total_reg, total_next;
    logic [FW-1:0]       chi_reg, chi_next;
    logic [FW-1:0]       clo_reg, clo_next;
    logic [CB-1:0]       hiq_reg, hiq_next;
    logic [CB-1:0]       low_reg, low_next;
    logic [CB-1:0]       high_reg, high_next;
    logic [CB-1:0]       pend_reg, pend_next;
    logic [NW-1:0]       nbit_reg, nbit_next;
    logic [IW-1:0]       walk_reg, walk_next;
    logic [FW-1:0]       sum_reg, sum_next;
    logic [FW-1:0]       fref_reg, fref_next;
    logic [IW-1:0]       srch_reg, srch_next;
    logic [SW-1:0]       sa_reg, sa_next;
    logic                ovalid_reg, ovalid_next;
    logic                olead_reg, olead_next;
    logic [CB-1:0]       ofollow_reg, ofollow_next;
    logic                olast_reg, olast_next;

    // Table ports
    logic          f_we, c_we, s_we, i_we;
    logic [IW-1:0] f_waddr, f_raddr, c_waddr, c_raddr, i_waddr, i_raddr;
    logic [SW-1:0] s_waddr, s_raddr;
    logic [FW-1:0] f_wdata, f_rdata, c_wdata, c_rdata;
    logic [IW-1:0] s_wdata, s_rdata;
    logic [SW-1:0] i_wdata, i_rdata;

    aae_pkg::md_req_t md_req;
    aae_pkg::md_rsp_t md_rsp;

    logic [IW-1:0] as1;
    logic [CB-1:0] span;
    logic          slot_free;
    logic [FW-1:0] half;
    logic [SW-1:0] sym_sat;
    logic          more;

    aae_ram #(.DEPTH(aae_pkg::NUM_IDX), .WIDTH(FW)) u_freq (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .raddr(f_raddr), .rdata(f_rdata)
    );

    aae_ram #(.DEPTH(aae_pkg::NUM_IDX), .WIDTH(FW)) u_cum (
        .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    aae_ram #(.DEPTH(aae_pkg::NUM_SYM), .WIDTH(IW)) u_s2i (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    aae_ram #(.DEPTH(aae_pkg::NUM_IDX), .WIDTH(SW)) u_i2s (
        .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
        .raddr(i_raddr), .rdata(i_rdata)
    );

    aae_muldiv u_md (
        .clk(clk), .rst_n(rst_n), .req(md_req), .rsp(md_rsp)
    );

    assign as1       = {1'b0, alpha_reg} + IW'(1);
    assign span      = high_reg - low_reg;
    assign slot_free = !ovalid_reg || bit_out.ready;
    assign half      = (f_rdata >> 1) + FW'(f_rdata[0]);
    assign sym_sat   = (sym_in.symbol > alpha_reg) ? alpha_reg : sym_in.symbol;
    assign more      = (low_reg[CB-2] == high_reg[CB-2]) && (nbit_reg < NW'(CB - 1));

    // Hold off symbols while a configuration transfer is offered
    assign cfg.ready        = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign sym_in.ready     = (state_reg == S_IDLE) && !cfg.valid;
    assign bit_out.valid    = ovalid_reg;
    assign bit_out.lead_bit = olead_reg;
    assign bit_out.follow_count = ofollow_reg;
    assign bit_out.last     = olast_reg;

    // Sequence one symbol through narrowing, bit output and model update
    always_comb
    begin
        state_next   = state_reg;
        alpha_next   = alpha_reg;
        action_next  = action_reg;
        sym_next     = sym_reg;
        idx_next     = idx_reg;
        tot_raw_next = tot_raw_reg;
        total_next   = total_reg;
        chi_next     = chi_reg;
        clo_next     = clo_reg;
        hiq_next     = hiq_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        pend_next    = pend_reg;
        nbit_next    = nbit_reg;
        walk_next    = walk_reg;
        sum_next     = sum_reg;
        fref_next    = fref_reg;
        srch_next    = srch_reg;
        sa_next      = sa_reg;
        ovalid_next  = ovalid_reg && !bit_out.ready;
        olead_next   = olead_reg;
        ofollow_next = ofollow_reg;
        olast_next   = olast_reg;

        f_we = 1'b0; f_waddr = walk_reg; f_wdata = '0; f_raddr = '0;
        c_we = 1'b0; c_waddr = walk_reg; c_wdata = '0; c_raddr = '0;
        s_we = 1'b0; s_waddr = walk_reg[SW-1:0]; s_wdata = '0; s_raddr = sym_reg;
        i_we = 1'b0; i_waddr = walk_reg; i_wdata = '0; i_raddr = srch_reg;

        md_req.start   = 1'b0;
        md_req.mult    = chi_reg;
        md_req.span    = span;
        md_req.divisor = total_reg;

        case (state_reg)
            S_CLEAR:
            begin
                // Rebuild one entry of every table per cycle
                f_we    = 1'b1;
                f_wdata = (walk_reg == '0 || walk_reg > as1) ? FW'(0) : FW'(1);
                c_we    = 1'b1;
                c_wdata = (walk_reg <= as1) ? FW'(as1 - walk_reg) : FW'(0);
                i_we    = 1'b1;
                i_wdata = (walk_reg == '0) ? SW'(0) : SW'(walk_reg - IW'(1));
                s_we    = (walk_reg < IW'(aae_pkg::NUM_SYM));
                s_wdata = walk_reg + IW'(1);
                walk_next = walk_reg + IW'(1);
                if (walk_reg == IW'(aae_pkg::NUM_IDX - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (sym_in.valid && sym_in.ready)
                begin
                    action_next = sym_in.action;
                    sym_next    = sym_sat;
                    state_next  = S_IDX;
                end
            end
            S_IDX:
            begin
                s_raddr    = sym_reg;
                state_next = S_IDX_W;
            end
            S_IDX_W:
            begin
                if (s_rdata < IW'(1))
                begin
                    idx_next = IW'(1);
                end
                else if (s_rdata > as1)
                begin
                    idx_next = as1;
                end
                else
                begin
                    idx_next = s_rdata;
                end
                c_raddr    = '0;
                state_next = S_TOT;
            end
            S_TOT:
            begin
                tot_raw_next = c_rdata;
                total_next   = (c_rdata == '0) ? FW'(1) : c_rdata;
                c_raddr      = idx_reg - IW'(1);
                state_next   = S_CHI;
            end
            S_CHI:
            begin
                chi_next   = c_rdata;
                c_raddr    = idx_reg;
                state_next = S_CLO;
            end
            S_CLO:
            begin
                clo_next     = c_rdata;
                md_req.start = 1'b1;
                state_next   = S_DIV_HI;
            end
            S_DIV_HI:
            begin
                md_req.mult = clo_reg;
                if (md_rsp.done)
                begin
                    hiq_next     = md_rsp.quotient;
                    md_req.start = 1'b1;
                    state_next   = S_DIV_LO;
                end
            end
            S_DIV_LO:
            begin
                md_req.mult = clo_reg;
                if (md_rsp.done)
                begin
                    high_next  = low_reg + hiq_reg;
                    low_next   = low_reg + md_rsp.quotient;
                    nbit_next  = '0;
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                // Emit each settled top bit with the pending complements
                if (low_reg[CB-1] == high_reg[CB-1] && nbit_reg < NW'(CB))
                begin
                    if (slot_free)
                    begin
                        ovalid_next  = 1'b1;
                        olead_next   = low_reg[CB-1];
                        ofollow_next = pend_reg;
                        olast_next   = !action_reg && !more;
                        pend_next    = '0;
                        low_next     = low_reg << 1;
                        high_next    = (high_reg << 1) | CB'(1);
                        nbit_next    = nbit_reg + NW'(1);
                    end
                end
                else
                begin
                    state_next = S_UFLOW;
                end
            end
            S_UFLOW:
            begin
                // Expand around the midpoint while the range straddles it
                if (low_reg[CB-2] && !high_reg[CB-2])
                begin
                    if (pend_reg != '1)
                    begin
                        pend_next = pend_reg + CB'(1);
                    end
                    low_next  = (low_reg << 1) ^ (CB'(1) << (CB - 1));
                    high_next = (high_reg << 1) | (CB'(1) << (CB - 1)) | CB'(1);
                end
                else
                begin
                    state_next = action_reg ? S_FINAL : S_ADAPT;
                end
            end
            S_FINAL:
            begin
                if (slot_free)
                begin
                    ovalid_next  = 1'b1;
                    olead_next   = 1'b1;
                    ofollow_next = '0;
                    olast_next   = 1'b1;
                    state_next   = S_ADAPT;
                end
            end
            S_ADAPT:
            begin
                sum_next  = '0;
                walk_next = as1;
                srch_next = idx_reg;
                if (32'(tot_raw_reg) >= 32'(aae_pkg::TOTAL_LIMIT))
                begin
                    state_next = S_H_RD;
                end
                else
                begin
                    state_next = S_F_RD;
                end
            end
            S_H_RD:
            begin
                f_raddr    = walk_reg;
                state_next = S_H_WR;
            end
            S_H_WR:
            begin
                // Halve each frequency, rounding up, and rebuild cumulatives
                f_we     = 1'b1;
                f_wdata  = half;
                c_we     = 1'b1;
                c_wdata  = sum_reg;
                sum_next = sum_reg + half;
                if (walk_reg == '0)
                begin
                    state_next = S_F_RD;
                end
                else
                begin
                    walk_next  = walk_reg - IW'(1);
                    state_next = S_H_RD;
                end
            end
            S_F_RD:
            begin
                f_raddr    = idx_reg;
                state_next = S_F_REF;
            end
            S_F_REF:
            begin
                fref_next  = f_rdata;
                state_next = (srch_reg > IW'(1)) ? S_S_RD : S_SW_A;
            end
            S_S_RD:
            begin
                f_raddr    = srch_reg - IW'(1);
                state_next = S_S_CMP;
            end
            S_S_CMP:
            begin
                // Step over entries with the same frequency
                if (f_rdata == fref_reg)
                begin
                    srch_next  = srch_reg - IW'(1);
                    state_next = (srch_reg - IW'(1) > IW'(1)) ? S_S_RD : S_SW_A;
                end
                else
                begin
                    state_next = S_SW_A;
                end
            end
            S_SW_A:
            begin
                i_raddr    = srch_reg;
                state_next = (srch_reg < idx_reg) ? S_SW_B : S_INC;
            end
            S_SW_B:
            begin
                sa_next    = i_rdata;
                i_raddr    = idx_reg;
                state_next = S_SW_C;
            end
            S_SW_C:
            begin
                i_we       = 1'b1;
                i_waddr    = srch_reg;
                i_wdata    = i_rdata;
                sym_next   = i_rdata;
                state_next = S_SW_D;
            end
            S_SW_D:
            begin
                i_we       = 1'b1;
                i_waddr    = idx_reg;
                i_wdata    = sa_reg;
                s_we       = 1'b1;
                s_waddr    = sa_reg;
                s_wdata    = idx_reg;
                state_next = S_SW_E;
            end
            S_SW_E:
            begin
                s_we       = 1'b1;
                s_waddr    = sym_reg;
                s_wdata    = srch_reg;
                state_next = S_INC;
            end
            S_INC:
            begin
                f_we       = 1'b1;
                f_waddr    = srch_reg;
                f_wdata    = fref_reg + FW'(1);
                walk_next  = srch_reg - IW'(1);
                state_next = S_C_RD;
            end
            S_C_RD:
            begin
                c_raddr    = walk_reg;
                state_next = S_C_WR;
            end
            S_C_WR:
            begin
                // Advance every cumulative above the coded entry
                c_we    = 1'b1;
                c_wdata = c_rdata + FW'(1);
                if (walk_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    walk_next  = walk_reg - IW'(1);
                    state_next = S_C_RD;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
                walk_next  = '0;
            end
        endcase

        // A configuration transfer restarts the model from uniform
        if (cfg.valid && cfg.ready)
        begin
            alpha_next = cfg.max_symbol;
            walk_next  = '0;
            low_next   = '0;
            high_next  = '1;
            pend_next  = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            alpha_reg  <= aae_pkg::ALPHA_RESET;
            walk_reg   <= '0;
            low_reg    <= '0;
            high_reg   <= '1;
            pend_reg   <= '0;
            nbit_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            alpha_reg  <= alpha_next;
            walk_reg   <= walk_next;
            low_reg    <= low_next;
            high_reg   <= high_next;
            pend_reg   <= pend_next;
            nbit_reg   <= nbit_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg  <= action_next;
        sym_reg     <= sym_next;
        idx_reg     <= idx_next;
        tot_raw_reg <= tot_raw_next;
        total_reg   <= total_next;
        chi_reg     <= chi_next;
        clo_reg     <= clo_next;
        hiq_reg     <= hiq_next;
        sum_reg     <= sum_next;
        fref_reg    <= fref_next;
        srch_reg    <= srch_next;
        sa_reg      <= sa_next;
        olead_reg   <= olead_next;
        ofollow_reg <= ofollow_next;
        olast_reg   <= olast_next;
    end

    `AAE_ASSERT_SAME(a_range_order, clk, rst_n, (state_reg == S_SETTLE || state_reg == S_UFLOW), (low_reg <= high_reg), "range low above range high")
    `AAE_ASSERT_SAME(a_bit_bound, clk, rst_n, (state_reg == S_SETTLE), (nbit_reg <= NW'(CB)), "too many settled bits")
    `AAE_ASSERT_NEXT(a_accept_seq, clk, rst_n, (sym_in.valid && sym_in.ready && !cfg.valid), (state_reg == S_IDX), "symbol transfer did not start coding")
    `AAE_ASSERT_NEXT(a_cfg_clear, clk, rst_n, (cfg.valid && cfg.ready), (state_reg == S_CLEAR && walk_reg == '0), "configuration did not restart clearing")

endmodule

>>> dv/adaptive_arithmetic_encoder_checker.sv
// Checker of the arithmetic encoder: predicts the bit stream and compares each transfer.
`timescale 1ns / 1ps
module adaptive_arithmetic_encoder_checker (
    input  logic        clk,
    input  logic        rst_n,
    aae_cfg_if          cfg,
    aae_sym_if          sym_in,
    aae_bit_if          bit_out,
    output int unsigned error_count,
    output int unsigned outstanding
);

    typedef struct {
        logic                          lead_bit;
        logic [aae_pkg::CODE_BITS-1:0] follow_count;
        logic                          last;
    } coded_bit_t;

    coded_bit_t expected_bits[$];

    // Coder state kept by the checker
    logic [aae_pkg::SYM_W-1:0]     alpha;
    logic [aae_pkg::CODE_BITS-1:0] span_low;
    logic [aae_pkg::CODE_BITS-1:0] span_high;
    logic [aae_pkg::CODE_BITS-1:0] follow_pend;
    logic [31:0]                   freq[aae_pkg::NUM_IDX];
    logic [31:0]                   cum[aae_pkg::NUM_IDX];
    logic [aae_pkg::IDX_W-1:0]     sym_idx[aae_pkg::NUM_SYM];
    logic [aae_pkg::SYM_W-1:0]     idx_sym[aae_pkg::NUM_IDX];

    assign outstanding = expected_bits.size();

    task automatic report(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // Rebuild a uniform model and reset the range
    task automatic rebuild_model(input logic [aae_pkg::SYM_W-1:0] size);
        alpha       = size;
        span_low    = '0;
        span_high   = '1;
        follow_pend = '0;
        for (int i = 0; i < aae_pkg::NUM_IDX; i++)
        begin
            freq[i]    = (i == 0 || i > size + 1) ? 0 : 1;
            cum[i]     = (i <= size + 1) ? size + 1 - i : 0;
            idx_sym[i] = (i == 0) ? '0 : aae_pkg::SYM_W'(i - 1);
        end
        for (int i = 0; i < aae_pkg::NUM_SYM; i++)
            sym_idx[i] = aae_pkg::IDX_W'(i + 1);
    endtask

    // Halve if needed, move the symbol ahead of equal frequencies, count it
    task automatic adapt_model(input int idx);
        int                        i;
        logic [31:0]               sum;
        logic [aae_pkg::SYM_W-1:0] sa;
        logic [aae_pkg::SYM_W-1:0] sb;
        if (cum[0] >= aae_pkg::TOTAL_LIMIT)
        begin
            sum = 0;
            for (i = alpha + 1; i >= 0; i--)
            begin
                freq[i] = (freq[i] >> 1) + (freq[i] & 1);
                cum[i]  = sum;
                sum     = sum + freq[i];
            end
        end
        i = idx;
        while (i > 1 && freq[i] == freq[i-1])
            i--;
        if (i < idx)
        begin
            sa          = idx_sym[i];
            sb          = idx_sym[idx];
            idx_sym[i]  = sb;
            idx_sym[idx] = sa;
            sym_idx[sa] = aae_pkg::IDX_W'(idx);
            sym_idx[sb] = aae_pkg::IDX_W'(i);
        end
        freq[i]++;
        while (i > 0)
        begin
            i--;
            cum[i]++;
        end
    endtask

    // Code one symbol and queue the settled bits it yields
    task automatic encode_symbol(input logic action,
                                 input logic [aae_pkg::SYM_W-1:0] symbol);
        logic [aae_pkg::SYM_W-1:0]     s;
        int                            idx;
        int                            n;
        logic [31:0]                   total;
        logic [63:0]                   width;
        logic [aae_pkg::CODE_BITS-1:0] base;
        coded_bit_t                    cb;
        s   = (symbol > alpha) ? alpha : symbol;
        idx = sym_idx[s];
        if (idx < 1)
            idx = 1;
        if (idx > alpha + 1)
            idx = alpha + 1;
        total = (cum[0] == 0) ? 1 : cum[0];
        width = 64'(span_high - span_low);
        base  = span_low;
        span_high = base + aae_pkg::CODE_BITS'(64'(cum[idx-1]) * width / 64'(total));
        span_low  = base + aae_pkg::CODE_BITS'(64'(cum[idx]) * width / 64'(total));
        n = 0;
        while (span_low[aae_pkg::TOP_BIT] == span_high[aae_pkg::TOP_BIT]
               && n < aae_pkg::CODE_BITS)
        begin
            cb.lead_bit     = span_low[aae_pkg::TOP_BIT];
            cb.follow_count = follow_pend;
            cb.last         = 1'b0;
            expected_bits.push_back(cb);
            n++;
            follow_pend = '0;
            span_low    = span_low << 1;
            span_high   = (span_high << 1) | 1;
        end
        // Underflow: shift out the second bit and count a pending complement
        while (span_low[aae_pkg::TOP_BIT-1] && !span_high[aae_pkg::TOP_BIT-1])
        begin
            if (follow_pend != '1)
                follow_pend++;
            span_low  = (span_low << 1) ^ (1 << aae_pkg::TOP_BIT);
            span_high = (span_high << 1) | (1 << aae_pkg::TOP_BIT) | 1;
        end
        adapt_model(idx);
        if (action)
        begin
            cb.lead_bit     = 1'b1;
            cb.follow_count = '0;
            cb.last         = 1'b0;
            expected_bits.push_back(cb);
            n++;
        end
        if (n > 0)
            expected_bits[$].last = 1'b1;
    endtask

    // Watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        coded_bit_t want;
        if (!rst_n)
        begin
            error_count = 0;
            expected_bits.delete();
            rebuild_model(aae_pkg::ALPHA_RESET);
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                rebuild_model(cfg.max_symbol);
            if (sym_in.valid && sym_in.ready)
                encode_symbol(sym_in.action, sym_in.symbol);
            if (bit_out.valid && bit_out.ready)
            begin
                if (expected_bits.size() == 0)
                    report("bit transfer with nothing expected");
                else
                begin
                    want = expected_bits.pop_front();
                    if (bit_out.lead_bit !== want.lead_bit)
                        report($sformatf("lead_bit %b, expected %b",
                                         bit_out.lead_bit, want.lead_bit));
                    if (bit_out.follow_count !== want.follow_count)
                        report($sformatf("follow_count %0d, expected %0d",
                                         bit_out.follow_count, want.follow_count));
                    if (bit_out.last !== want.last)
                        report($sformatf("last %b, expected %b", bit_out.last, want.last));
                end
            end
        end
    end
endmodule

>>> dv/adaptive_arithmetic_encoder_tb.sv
// Testbench top of the arithmetic encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module adaptive_arithmetic_encoder_tb;

    logic        clk;
    logic        rst_n;
    int unsigned error_count;
    int unsigned outstanding;
    logic        steady;
    int          stall_left;

    aae_cfg_if cfg_ch ();
    aae_sym_if sym_ch ();
    aae_bit_if bit_ch ();

    adaptive_arithmetic_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .sym_in  (sym_ch),
        .bit_out (bit_ch)
    );

    adaptive_arithmetic_encoder_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_ch),
        .sym_in      (sym_ch),
        .bit_out     (bit_ch),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Mostly short gaps, a few long ones; none while steady
    function automatic int pick_gap();
        if (steady)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(2);
    endfunction

    // Receiver stalls: one ready cycle, then a random gap
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            bit_ch.ready = 1'b0;
            stall_left   = 0;
        end
        else if (stall_left > 0)
        begin
            bit_ch.ready = 1'b0;
            stall_left   = stall_left - 1;
        end
        else
        begin
            bit_ch.ready = 1'b1;
            stall_left   = pick_gap();
        end
    end

    task automatic settle();
        wait (outstanding == 0);
        repeat (2500) @(negedge clk);
    endtask

    task automatic write_alphabet(input logic [aae_pkg::SYM_W-1:0] size);
        settle();
        cfg_ch.valid      = 1'b1;
        cfg_ch.max_symbol = size;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic send_symbol(input logic action, input logic [aae_pkg::SYM_W-1:0] symbol);
        int gap;
        sym_ch.valid  = 1'b1;
        sym_ch.action = action;
        sym_ch.symbol = symbol;
        do @(posedge clk); while (!sym_ch.ready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            sym_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random symbols: a few favorites often, to drive the model's reordering
    task automatic random_phase(input logic [aae_pkg::SYM_W-1:0] size, input int count);
        logic [aae_pkg::SYM_W-1:0] favs[4];
        logic [aae_pkg::SYM_W-1:0] s;
        for (int k = 0; k < 4; k++)
            favs[k] = aae_pkg::SYM_W'($urandom_range(size));
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3: s = favs[$urandom_range(3)];
                4:          s = aae_pkg::SYM_W'($urandom);
                default:    s = aae_pkg::SYM_W'($urandom_range(size));
            endcase
            send_symbol($urandom_range(6) == 0, s);
        end
        sym_ch.valid = 1'b0;
    endtask

    initial
    begin
        rst_n             = 1'b0;
        steady            = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.max_symbol = '0;
        sym_ch.valid      = 1'b0;
        sym_ch.action     = 1'b0;
        sym_ch.symbol     = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset alphabet, field extremes, symbol above alphabet, final bit
        send_symbol(1'b0, 9'd0);
        send_symbol(1'b0, 9'd256);
        send_symbol(1'b0, 9'd511);
        send_symbol(1'b1, 9'd255);
        send_symbol(1'b0, 9'd0);
        send_symbol(1'b0, 9'd0);
        send_symbol(1'b1, 9'd0);
        sym_ch.valid = 1'b0;
        write_alphabet(9'd511);
        send_symbol(1'b0, 9'd511);
        send_symbol(1'b0, 9'h155);
        send_symbol(1'b0, 9'h0AA);
        send_symbol(1'b1, 9'd511);
        sym_ch.valid = 1'b0;
        write_alphabet(9'd1);
        send_symbol(1'b0, 9'd1);
        send_symbol(1'b0, 9'd1);
        send_symbol(1'b0, 9'd0);
        send_symbol(1'b1, 9'd300);
        sym_ch.valid = 1'b0;
        write_alphabet(9'd0);
        send_symbol(1'b0, 9'd0);
        send_symbol(1'b1, 9'd7);
        sym_ch.valid = 1'b0;

        // Random phases over several alphabet sizes
        write_alphabet(9'd3);
        random_phase(9'd3, 15);
        write_alphabet(9'd511);
        random_phase(9'd511, 20);
        write_alphabet(9'd40);
        steady = 1'b1;
        random_phase(9'd40, 15);
        steady = 1'b0;
        write_alphabet(9'd1);
        random_phase(9'd1, 12);
        write_alphabet(9'd256);
        random_phase(9'd256, 30);

        settle();
        if (error_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

>>> sim.f
+incdir+sv
sv/aae_pkg.sv
sv/aae_if.sv
sv/aae_ram.sv
sv/aae_muldiv.sv
sv/adaptive_arithmetic_encoder.sv
dv/adaptive_arithmetic_encoder_checker.sv
dv/adaptive_arithmetic_encoder_tb.sv
